// ===== src/modular_exponentiation_macros.svh =====
// assertion macros shared by the checker
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MEXP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/mexp_pkg.sv =====
package mexp_pkg;

    localparam int FIELD_W   = 64;
    localparam int WORD_BITS = 64;
    localparam int CNT_W     = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MODULUS  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_EXPONENT = CFG_ADDR_W'(1);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_HOLD
    } mexp_state_t;

    typedef struct packed {
        logic  start;
        word_t a;
        word_t b;
    } mul_req_t;

    typedef struct packed {
        logic  done;
        word_t product;
    } mul_rsp_t;

endpackage

// ===== src/mexp_modmul.sv =====
module mexp_modmul (
    input  logic               clk,
    input  logic               rst_n,
    input  mexp_pkg::word_t    n,
    input  mexp_pkg::mul_req_t req,
    output mexp_pkg::mul_rsp_t rsp
);
    import mexp_pkg::*;

    localparam int SUM_W = WORD_BITS + 2;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            a_reg, a_next;
    word_t            b_reg, b_next;
    word_t            acc_reg, acc_next;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] n1;
    logic [SUM_W-1:0] n2;
    word_t            step;

    // acc = 2*acc + bit*a, both below n, so the sum stays below 3n
    always_comb
    begin
        n1  = SUM_W'(n);
        n2  = n1 << 1;
        sum = {1'b0, acc_reg, 1'b0} + SUM_W'(b_reg[WORD_BITS-1] ? a_reg : '0);
        if (sum >= n2)
        begin
            step = word_t'(sum - n2);
        end
        else if (sum >= n1)
        begin
            step = word_t'(sum - n1);
        end
        else
        begin
            step = word_t'(sum);
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            acc_next = step;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WORD_BITS - 1);
            a_next    = req.a;
            b_next    = req.b;
            acc_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = acc_reg;

endmodule

// ===== src/mexp_seq.sv =====
module mexp_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mexp_pkg::word_t              n,
    input  mexp_pkg::word_t              exponent,
    input  logic                         message_valid,
    output logic                         message_ready,
    input  logic [mexp_pkg::FIELD_W-1:0] message,
    output logic                         result_valid,
    input  logic                         result_ready,
    output logic [mexp_pkg::FIELD_W-1:0] result,
    output mexp_pkg::mul_req_t           mul_req,
    input  mexp_pkg::mul_rsp_t           mul_rsp
);
    import mexp_pkg::*;

    mexp_state_t      state_reg, state_next;
    logic             pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            exp_reg, exp_next;
    word_t            base_reg, base_next;
    word_t            acc_reg, acc_next;
    word_t            result_reg, result_next;

    logic  accept;
    logic  load;
    logic  last_bit;
    word_t one_mod;

    assign accept   = message_valid && message_ready;
    assign last_bit = (cnt_reg == '0);
    assign one_mod  = (n == word_t'(1)) ? '0 : word_t'(1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (n == '0) ? ST_HOLD : ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                if (mul_rsp.done)
                begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    if (exp_reg[WORD_BITS-1])
                    begin
                        state_next = ST_MULT;
                    end
                    else
                    begin
                        state_next = last_bit ? ST_HOLD : ST_SQUARE;
                    end
                end
            end
            ST_MULT:
            begin
                if (mul_rsp.done)
                begin
                    state_next = last_bit ? ST_HOLD : ST_SQUARE;
                end
            end
            ST_HOLD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and multiplier requests
    always_comb
    begin
        message_ready = 1'b0;
        load          = 1'b0;
        mul_req.start = 1'b0;
        mul_req.a     = acc_reg;
        mul_req.b     = acc_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                message_ready = 1'b1;
            end
            ST_REDUCE:
            begin
                // message * (1 mod n) reduces the message
                mul_req.start = !pend_reg && !mul_rsp.done;
                mul_req.a     = one_mod;
                mul_req.b     = base_reg;
            end
            ST_SQUARE:
            begin
                mul_req.start = !pend_reg && !mul_rsp.done;
            end
            ST_MULT:
            begin
                mul_req.start = !pend_reg && !mul_rsp.done;
                mul_req.a     = base_reg;
            end
            ST_HOLD:
            begin
                load = !out_valid_reg || result_ready;
            end
            default:
            begin
                message_ready = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        pend_next   = pend_reg;
        cnt_next    = cnt_reg;
        exp_next    = exp_reg;
        base_next   = base_reg;
        acc_next    = acc_reg;
        result_next = result_reg;

        if (mul_req.start)
        begin
            pend_next = 1'b1;
        end
        else if (mul_rsp.done)
        begin
            pend_next = 1'b0;
        end

        if (accept)
        begin
            base_next = message[WORD_BITS-1:0];
            acc_next  = '0;
        end

        if (mul_rsp.done)
        begin
            if (state_reg == ST_REDUCE)
            begin
                base_next = mul_rsp.product;
                acc_next  = one_mod;
                exp_next  = exponent;
                cnt_next  = CNT_W'(WORD_BITS - 1);
            end
            else
            begin
                acc_next = mul_rsp.product;
                if (state_reg == ST_MULT || !exp_reg[WORD_BITS-1])
                begin
                    exp_next = exp_reg << 1;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
        end

        if (load)
        begin
            result_next = acc_reg;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        exp_reg    <= exp_next;
        base_reg   <= base_next;
        acc_reg    <= acc_next;
        result_reg <= result_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = FIELD_W'(result_reg);

endmodule

// ===== src/modular_exponentiation.sv =====
// channel   | signals                                   | word
// ----------+-------------------------------------------+---------------------------
// input     | message_valid, message_ready, message     | base word to exponentiate
// output    | result_valid, result_ready, result        | message^exponent mod modulus
// config    | cfg_wr_en, cfg_addr, cfg_wdata            | modulus (0), exponent (1)
//
// one word at a time: a reduce pass, then a square per exponent bit and a multiply per set bit
// each modular multiply is bit serial (start, one step per multiplier bit, done) in one shared unit
// modulus zero skips the arithmetic and returns zero
// result register holds a finished word under output stall; a new word is taken meanwhile
// reset (rst_n low, async) sets modulus and exponent to 1 and empties the block
module modular_exponentiation (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mexp_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mexp_pkg::FIELD_W-1:0]    cfg_wdata,
    input  logic                            message_valid,
    output logic                            message_ready,
    input  logic [mexp_pkg::FIELD_W-1:0]    message,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic [mexp_pkg::FIELD_W-1:0]    result
);
    import mexp_pkg::*;

    word_t    modulus_reg, modulus_next;
    word_t    exponent_reg, exponent_next;
    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    always_comb
    begin
        modulus_next  = modulus_reg;
        exponent_next = exponent_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_MODULUS:  modulus_next  = cfg_wdata[WORD_BITS-1:0];
                REG_EXPONENT: exponent_next = cfg_wdata[WORD_BITS-1:0];
                default:      modulus_next  = modulus_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= word_t'(1);
            exponent_reg <= word_t'(1);
        end
        else
        begin
            modulus_reg  <= modulus_next;
            exponent_reg <= exponent_next;
        end
    end

    mexp_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .n             (modulus_reg),
        .exponent      (exponent_reg),
        .message_valid (message_valid),
        .message_ready (message_ready),
        .message       (message),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .mul_req       (mul_req),
        .mul_rsp       (mul_rsp)
    );

    mexp_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .n     (modulus_reg),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

endmodule

// ===== src/mexp_checker.sv =====
`include "modular_exponentiation_macros.svh"

module mexp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         message_valid,
    input logic                         message_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic [mexp_pkg::FIELD_W-1:0] result
);
    import mexp_pkg::*;

    // one word in flight: busy right after taking one
    `MEXP_ASSERT_NEXT(a_busy_after_take, message_valid && message_ready, !message_ready)

    // a new result only ever follows a busy cycle
    `MEXP_ASSERT_NOW(a_result_after_work, $rose(result_valid), $past(!message_ready))

    // stalled result word holds
    `MEXP_ASSERT_NEXT(a_result_held, result_valid && !result_ready, result_valid && $stable(result))

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (.*);
